@@ rtl/core/ghab_pkg.sv @@
// shared types, constants and decode helpers for the hat/axis button core
package ghab_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int MAX_HOLDS   = 16;
  localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int HIW = (MAX_HOLDS > 1) ? $clog2(MAX_HOLDS) : 1;
  localparam int HCW = $clog2(MAX_HOLDS + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OIW = $clog2(OUT_DEPTH);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  // part codes
  localparam logic [2:0] PART_W = 3'd0;
  localparam logic [2:0] PART_E = 3'd1;
  localparam logic [2:0] PART_N = 3'd2;
  localparam logic [2:0] PART_S = 3'd3;
  localparam logic [2:0] PART_L = 3'd4;
  localparam logic [2:0] PART_H = 3'd5;
  localparam logic [2:0] PART_B = 3'd6;

  typedef enum logic [1:0] {
    OP_DEF_HAT  = 2'd0,
    OP_DEF_AXIS = 2'd1,
    OP_INPUT    = 2'd2,
    OP_RELEASE  = 2'd3
  } op_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t                op;
    logic [15:0]        id;
    logic signed [15:0] value;
    logic signed [15:0] mid;
    logic signed [16:0] lo_thr;
    logic signed [16:0] hi_thr;
  } cmd_t;

  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  part;
    logic        pressed;
    logic        last;
  } res_t;

  typedef struct packed {
    logic w;
    logic e;
    logic n;
    logic s;
  } dir_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EXEC,
    BS_EMIT,
    BS_REL_ENT,
    BS_REL_HOLD,
    BS_FLUSH
  } bstate_t;

  // eight-way hat position relative to its range low
  function automatic dir_t hat_dir(input logic signed [17:0] d);
    dir_t r;
    r.w = (d == 18'sd5) || (d == 18'sd6) || (d == 18'sd7);
    r.e = (d == 18'sd1) || (d == 18'sd2) || (d == 18'sd3);
    r.n = (d == 18'sd7) || (d == 18'sd0) || (d == 18'sd1);
    r.s = (d == 18'sd3) || (d == 18'sd4) || (d == 18'sd5);
    return r;
  endfunction

endpackage

@@ rtl/core/ghab_front.sv @@
// front stage: accepts words and classifies them, working out axis thresholds
module ghab_front import ghab_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic [15:0]        button_id,
  input  logic signed [15:0] value,
  input  logic signed [15:0] range_high,
  output cmd_t               cmd,
  output logic               cmd_valid,
  input  logic               cmd_full
);

  logic               take;
  logic signed [16:0] v17, h17, mid17, sum_mid, sum_lo, sum_hi, mlo, mhi;
  cmd_t               cmd_next;

  assign full = cmd_valid && cmd_full;
  assign take = push && !full;

  // threshold arithmetic
  always_comb begin
    v17     = {value[15], value};
    h17     = {range_high[15], range_high};
    sum_mid = v17 + h17;
    mid17   = sum_mid >>> 1;
    sum_lo  = v17 + mid17;
    sum_hi  = h17 + mid17;
    mlo     = sum_lo >>> 1;
    mhi     = sum_hi >>> 1;
    cmd_next.op     = op_t'(action);
    cmd_next.id     = button_id;
    cmd_next.value  = value;
    cmd_next.mid    = mid17[15:0];
    cmd_next.lo_thr = (mlo >= mid17) ? mid17 - 17'sd1 : mlo;
    cmd_next.hi_thr = (mhi <= mid17) ? mid17 + 17'sd1 : mhi;
    if (op_t'(action) == OP_DEF_HAT) begin
      cmd_next.lo_thr = v17;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (cmd_valid && !cmd_full) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

endmodule

@@ rtl/core/ghab_queue.sv @@
// two-entry command queue between front and back
module ghab_queue import ghab_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wdata,
  output logic full,
  input  logic rd,
  output cmd_t rdata,
  output logic empty
);

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_wr, do_rd;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) begin
        wp <= ~wp;
      end
      if (do_rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule

@@ rtl/core/ghab_back.sv @@
// back stage: entry table, hold list, event sequencing and result queue
module ghab_back import ghab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_data,
  output logic        q_rd,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] button_id_res,
  output logic [2:0]  part,
  output logic        pressed,
  output logic        last
);

  bstate_t state, state_next;
  cmd_t    cur;

  // entry table
  logic [15:0]        ent_id    [MAX_ENTRIES];
  logic               ent_axis  [MAX_ENTRIES];
  logic signed [16:0] ent_lo    [MAX_ENTRIES];
  logic signed [16:0] ent_hi    [MAX_ENTRIES];
  logic signed [15:0] ent_last  [MAX_ENTRIES];
  logic [3:0]         ent_flags [MAX_ENTRIES];
  logic [ECW-1:0]     ent_cnt;

  // hold list
  logic [15:0]    hold_ids [MAX_HOLDS];
  logic [HCW-1:0] hold_cnt;

  // event list of one input word
  logic [15:0] ev_id;
  logic [2:0]  ev_part [4];
  logic        ev_pr   [4];
  logic [2:0]  ev_n, ev_k;

  // release walk
  logic [ECW-1:0] ri;
  logic [1:0]     rb;

  // staged result and result queue
  res_t           pend;
  logic           pend_v;
  res_t           omem [OUT_DEPTH];
  logic [OIW-1:0] owp, orp;
  logic [OCW-1:0] ocnt;
  logic           o_full, o_push, o_pop;
  res_t           o_wdata;

  // lookups
  logic           hit_any, h_hit, can_ins;
  logic [EIW-1:0] hit_idx, ri_idx;
  logic [HIW-1:0] h_idx, h_top;
  logic [HCW-1:0] hcm1;
  logic [ECW-1:0] ins_pos;

  // event build
  logic               p_axis, do_upd, hold_push, hold_rm;
  logic signed [16:0] p_lo, p_hi, v17;
  logic signed [15:0] p_last;
  logic [3:0]         p_flags, nf;
  logic signed [17:0] d_prev, d_new;
  dir_t               pd, nd;
  logic               want_lo, want_hi;
  logic [2:0]         nl_part [4];
  logic               nl_pr   [4];
  logic [2:0]         nl_n;

  // emit control
  logic        emit_req, emit_go, rel_flag, rel_axis, rel_end_bit;
  logic [15:0] emit_id;
  logic [2:0]  emit_part;
  logic        emit_pr;

  assign q_rd = (state == BS_IDLE) && !q_empty;

  // table and hold searches
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    ins_pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (ECW'(i) < ent_cnt && ent_id[i] == cur.id) begin
        hit_any = 1'b1;
        hit_idx = EIW'(i);
      end
      if (ECW'(i) < ent_cnt && ent_id[i] < cur.id) begin
        ins_pos = ins_pos + ECW'(1);
      end
    end
    h_hit = 1'b0;
    h_idx = '0;
    for (int j = 0; j < MAX_HOLDS; j++) begin
      if (HCW'(j) < hold_cnt && hold_ids[j] == cur.id) begin
        h_hit = 1'b1;
        h_idx = HIW'(j);
      end
    end
    can_ins = !hit_any && (ent_cnt < ECW'(MAX_ENTRIES));
    hcm1    = hold_cnt - HCW'(1);
    h_top   = hcm1[HIW-1:0];
    ri_idx  = ri[EIW-1:0];
  end

  // events of one input change
  always_comb begin
    p_axis  = ent_axis[hit_idx];
    p_lo    = ent_lo[hit_idx];
    p_hi    = ent_hi[hit_idx];
    p_last  = ent_last[hit_idx];
    p_flags = ent_flags[hit_idx];
    v17     = {cur.value[15], cur.value};
    d_prev  = {{2{p_last[15]}}, p_last} - {p_lo[16], p_lo};
    d_new   = {{2{cur.value[15]}}, cur.value} - {p_lo[16], p_lo};
    pd      = hat_dir(d_prev);
    nd      = hat_dir(d_new);
    want_lo = v17 <= p_lo;
    want_hi = !want_lo && (v17 >= p_hi);
    do_upd  = cur.value != p_last;
    nf      = p_flags;
    hold_push = 1'b0;
    hold_rm   = 1'b0;
    nl_n    = 3'd0;
    for (int k = 0; k < 4; k++) begin
      nl_part[k] = PART_B;
      nl_pr[k]   = 1'b0;
    end
    if (cur.op == OP_INPUT) begin
      if (hit_any) begin
        if (do_upd && !p_axis) begin
          if ({pd.w, pd.e} != {nd.w, nd.e}) begin
            if (pd.w) begin
              nf[0] = 1'b0;
              nl_part[nl_n[1:0]] = PART_W; nl_pr[nl_n[1:0]] = 1'b0; nl_n = nl_n + 3'd1;
            end else if (pd.e) begin
              nf[1] = 1'b0;
              nl_part[nl_n[1:0]] = PART_E; nl_pr[nl_n[1:0]] = 1'b0; nl_n = nl_n + 3'd1;
            end
            if (nd.w) begin
              nf[0] = 1'b1;
              nl_part[nl_n[1:0]] = PART_W; nl_pr[nl_n[1:0]] = 1'b1; nl_n = nl_n + 3'd1;
            end else if (nd.e) begin
              nf[1] = 1'b1;
              nl_part[nl_n[1:0]] = PART_E; nl_pr[nl_n[1:0]] = 1'b1; nl_n = nl_n + 3'd1;
            end
          end
          if ({pd.n, pd.s} != {nd.n, nd.s}) begin
            if (pd.n) begin
              nf[2] = 1'b0;
              nl_part[nl_n[1:0]] = PART_N; nl_pr[nl_n[1:0]] = 1'b0; nl_n = nl_n + 3'd1;
            end else if (pd.s) begin
              nf[3] = 1'b0;
              nl_part[nl_n[1:0]] = PART_S; nl_pr[nl_n[1:0]] = 1'b0; nl_n = nl_n + 3'd1;
            end
            if (nd.n) begin
              nf[2] = 1'b1;
              nl_part[nl_n[1:0]] = PART_N; nl_pr[nl_n[1:0]] = 1'b1; nl_n = nl_n + 3'd1;
            end else if (nd.s) begin
              nf[3] = 1'b1;
              nl_part[nl_n[1:0]] = PART_S; nl_pr[nl_n[1:0]] = 1'b1; nl_n = nl_n + 3'd1;
            end
          end
        end else if (do_upd) begin
          if (!want_hi && nf[1]) begin
            nf[1] = 1'b0;
            nl_part[nl_n[1:0]] = PART_H; nl_pr[nl_n[1:0]] = 1'b0; nl_n = nl_n + 3'd1;
          end
          if (!want_lo && nf[0]) begin
            nf[0] = 1'b0;
            nl_part[nl_n[1:0]] = PART_L; nl_pr[nl_n[1:0]] = 1'b0; nl_n = nl_n + 3'd1;
          end
          if (want_lo && !nf[0]) begin
            nf[0] = 1'b1;
            nl_part[nl_n[1:0]] = PART_L; nl_pr[nl_n[1:0]] = 1'b1; nl_n = nl_n + 3'd1;
          end
          if (want_hi && !nf[1]) begin
            nf[1] = 1'b1;
            nl_part[nl_n[1:0]] = PART_H; nl_pr[nl_n[1:0]] = 1'b1; nl_n = nl_n + 3'd1;
          end
        end
      end else if (cur.value != 16'sd0) begin
        if (!h_hit && hold_cnt < HCW'(MAX_HOLDS)) begin
          hold_push = 1'b1;
          nl_part[0] = PART_B; nl_pr[0] = 1'b1; nl_n = 3'd1;
        end
      end else if (h_hit) begin
        hold_rm = 1'b1;
        nl_part[0] = PART_B; nl_pr[0] = 1'b0; nl_n = 3'd1;
      end
    end
  end

  // event source per state
  always_comb begin
    rel_axis    = ent_axis[ri_idx];
    rel_flag    = (ri < ent_cnt) && ent_flags[ri_idx][rb];
    rel_end_bit = rel_axis ? (rb == 2'd1) : (rb == 2'd3);
    emit_req    = 1'b0;
    emit_id     = ev_id;
    emit_part   = ev_part[ev_k[1:0]];
    emit_pr     = ev_pr[ev_k[1:0]];
    case (state)
      BS_EMIT: begin
        emit_req = 1'b1;
      end
      BS_REL_ENT: begin
        emit_req  = rel_flag;
        emit_id   = ent_id[ri_idx];
        emit_part = rel_axis ? PART_L + {1'b0, rb} : {1'b0, rb};
        emit_pr   = 1'b0;
      end
      BS_REL_HOLD: begin
        emit_req  = hold_cnt != '0;
        emit_id   = hold_ids[h_top];
        emit_part = PART_B;
        emit_pr   = 1'b0;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
    emit_go = emit_req && !o_full;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE: begin
        if (!q_empty) state_next = BS_EXEC;
      end
      BS_EXEC: begin
        if (cur.op == OP_RELEASE) state_next = BS_REL_ENT;
        else if (nl_n != 3'd0) state_next = BS_EMIT;
        else state_next = BS_FLUSH;
      end
      BS_EMIT: begin
        if (emit_go && ev_k == ev_n - 3'd1) state_next = BS_FLUSH;
      end
      BS_REL_ENT: begin
        if (ri >= ent_cnt) state_next = BS_REL_HOLD;
      end
      BS_REL_HOLD: begin
        if (hold_cnt == '0) state_next = BS_FLUSH;
      end
      BS_FLUSH: begin
        if (!pend_v || !o_full) state_next = BS_IDLE;
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  // result queue write side
  always_comb begin
    o_full  = (ocnt == OCW'(OUT_DEPTH));
    o_wdata = pend;
    o_wdata.last = (state == BS_FLUSH);
    o_push  = (emit_go && pend_v) || ((state == BS_FLUSH) && pend_v && !o_full);
    o_pop   = pop && !empty;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BS_IDLE;
      ent_cnt  <= '0;
      hold_cnt <= '0;
      pend_v   <= 1'b0;
      ocnt     <= '0;
      owp      <= '0;
      orp      <= '0;
    end else begin
      state <= state_next;
      if (state == BS_EXEC && (cur.op == OP_DEF_HAT || cur.op == OP_DEF_AXIS) && can_ins) begin
        ent_cnt <= ent_cnt + ECW'(1);
      end
      if (state == BS_EXEC && hold_push) begin
        hold_cnt <= hold_cnt + HCW'(1);
      end
      if (state == BS_EXEC && hold_rm) begin
        hold_cnt <= hcm1;
      end
      if (state == BS_REL_HOLD && emit_go) begin
        hold_cnt <= hcm1;
      end
      if (emit_go) begin
        pend_v <= 1'b1;
      end else if (state == BS_FLUSH && !o_full) begin
        pend_v <= 1'b0;
      end
      if (o_push) begin
        owp <= owp + OIW'(1);
      end
      if (o_pop) begin
        orp <= orp + OIW'(1);
      end
      ocnt <= ocnt + OCW'(o_push) - OCW'(o_pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
    if (emit_go) begin
      pend.id      <= emit_id;
      pend.part    <= emit_part;
      pend.pressed <= emit_pr;
      pend.last    <= 1'b0;
    end
    if (o_push) begin
      omem[owp] <= o_wdata;
    end
    case (state)
      BS_EXEC: begin
        ev_id <= cur.id;
        ev_n  <= nl_n;
        ev_k  <= 3'd0;
        ri    <= '0;
        rb    <= 2'd0;
        for (int k = 0; k < 4; k++) begin
          ev_part[k] <= nl_part[k];
          ev_pr[k]   <= nl_pr[k];
        end
        if ((cur.op == OP_DEF_HAT || cur.op == OP_DEF_AXIS) && can_ins) begin
          for (int i = 1; i < MAX_ENTRIES; i++) begin
            if (ECW'(i) > ins_pos) begin
              ent_id[i]    <= ent_id[i-1];
              ent_axis[i]  <= ent_axis[i-1];
              ent_lo[i]    <= ent_lo[i-1];
              ent_hi[i]    <= ent_hi[i-1];
              ent_last[i]  <= ent_last[i-1];
              ent_flags[i] <= ent_flags[i-1];
            end
          end
          ent_id[ins_pos[EIW-1:0]]    <= cur.id;
          ent_axis[ins_pos[EIW-1:0]]  <= (cur.op == OP_DEF_AXIS);
          ent_lo[ins_pos[EIW-1:0]]    <= cur.lo_thr;
          ent_hi[ins_pos[EIW-1:0]]    <= cur.hi_thr;
          ent_last[ins_pos[EIW-1:0]]  <= (cur.op == OP_DEF_AXIS) ? cur.mid : 16'sd0;
          ent_flags[ins_pos[EIW-1:0]] <= 4'd0;
        end
        if (cur.op == OP_INPUT && hit_any && do_upd) begin
          ent_last[hit_idx]  <= cur.value;
          ent_flags[hit_idx] <= nf;
        end
        if (hold_push) begin
          hold_ids[hold_cnt[HIW-1:0]] <= cur.id;
        end
        if (hold_rm) begin
          for (int j = 0; j < MAX_HOLDS - 1; j++) begin
            if (HIW'(j) >= h_idx && HCW'(j) < hcm1) begin
              hold_ids[j] <= hold_ids[j+1];
            end
          end
        end
      end
      BS_EMIT: begin
        if (emit_go) ev_k <= ev_k + 3'd1;
      end
      BS_REL_ENT: begin
        if (ri < ent_cnt && (!rel_flag || !o_full)) begin
          if (rel_flag) ent_flags[ri_idx][rb] <= 1'b0;
          if (rel_end_bit) begin
            rb <= 2'd0;
            ri <= ri + ECW'(1);
          end else begin
            rb <= rb + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result ports
  assign empty         = (ocnt == '0);
  assign button_id_res = omem[orp].id;
  assign part          = omem[orp].part;
  assign pressed       = omem[orp].pressed;
  assign last          = omem[orp].last;

  // checks
  a_ocnt: assert property (@(posedge clk) disable iff (rst)
    ocnt <= OCW'(OUT_DEPTH)) else $error("result queue overfilled");
  a_idle_pend: assert property (@(posedge clk) disable iff (rst)
    state == BS_IDLE |-> !pend_v) else $error("staged result left behind");
  a_ent_cnt: assert property (@(posedge clk) disable iff (rst)
    ent_cnt <= ECW'(MAX_ENTRIES)) else $error("entry count beyond table");
  a_hold_cnt: assert property (@(posedge clk) disable iff (rst)
    hold_cnt <= HCW'(MAX_HOLDS)) else $error("hold count beyond list");
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    o_push && state != BS_FLUSH |-> !o_wdata.last) else $error("early last mark");

endmodule

@@ rtl/core/gamepad_hat_axis_to_buttons_core.sv @@
// top level: hat/axis to digital button events for one controller
//
// Input channel (push/full): one word per raw controller event: define hat,
// define axis, input change or release all. A word is taken when push is
// high and full is low. Result channel (empty/pop): press/release events,
// oldest first, present while empty is low, taken when pop is high.
// The last event caused by a word carries last; words causing none give none.
// A word with no events passes the back stage states idle, exec and flush; a
// word with events adds one emit step per event, issued one per cycle while the
// result queue has room. Release all walks the entry table one flag bit per
// cycle (two or four per entry) while the result queue has room, then releases
// each held button, and each walk ends with a closing step.
// The front register and a two-word queue let input continue while the back
// stage works; a four-deep result queue decouples the receiver.
// When the receiver stalls, events back up into the result queue, the back
// stage waits, and full rises once the command queue and front fill.
// Reset clears the entry and hold counts and all queues; table contents are
// only read below the counts.
module gamepad_hat_axis_to_buttons_core import ghab_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic [15:0]        button_id,
  input  logic signed [15:0] value,
  input  logic signed [15:0] range_high,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        button_id_res,
  output logic [2:0]         part,
  output logic               pressed,
  output logic               last
);

  cmd_t f_cmd, q_cmd;
  logic f_valid, q_full, q_empty, q_rd;

  // classify
  ghab_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .button_id  (button_id),
    .value      (value),
    .range_high (range_high),
    .cmd        (f_cmd),
    .cmd_valid  (f_valid),
    .cmd_full   (q_full)
  );

  // decoupling queue
  ghab_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_valid),
    .wdata (f_cmd),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_cmd),
    .empty (q_empty)
  );

  // execute
  ghab_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_cmd),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .button_id_res (button_id_res),
    .part          (part),
    .pressed       (pressed),
    .last          (last)
  );

endmodule

@@ test/tb_top.sv @@
// testbench for the hat/axis to button event core: random and directed words, event scoreboard
`timescale 1ns / 1ps

module tb_top;
  import ghab_pkg::*;

  typedef struct {
    op_t               op;
    logic [15:0]       id;
    logic signed [15:0] val;
    logic signed [15:0] hi;
  } word_t;

  typedef struct {
    logic [15:0] id;
    logic [2:0]  part;
    logic        pressed;
    logic        last;
  } event_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] action = '0;
  logic [15:0] button_id = '0;
  logic signed [15:0] value = '0;
  logic signed [15:0] range_high = '0;
  logic empty;
  logic pop = 1'b0;
  logic [15:0] button_id_res;
  logic [2:0] part;
  logic pressed;
  logic last;

  word_t  pending_words[$];
  event_t expected_events[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     words_done = 1'b0;
  int     send_gap = 0;
  int     recv_gap = 0;
  int     hold_off = 0;
  int     words_sent = 0;

  // predictor state
  logic [15:0]        tbl_id[MAX_ENTRIES];
  bit                 tbl_axis[MAX_ENTRIES];
  int                 tbl_low[MAX_ENTRIES];
  int                 tbl_high[MAX_ENTRIES];
  int                 tbl_prev[MAX_ENTRIES];
  logic [3:0]         tbl_flags[MAX_ENTRIES];
  int                 tbl_count = 0;
  logic [15:0]        held[$];

  // ids used by the random part, kept few so words hit existing entries
  logic [15:0] id_pool[12] = '{16'h0000, 16'hFFFF, 16'h0010, 16'h0020, 16'h8000, 16'h7FFF,
                               16'h0100, 16'h0101, 16'h1234, 16'h4000, 16'h0003, 16'hA5A5};

  gamepad_hat_axis_to_buttons_core i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .button_id(button_id), .value(value), .range_high(range_high), .empty(empty),
    .pop(pop), .button_id_res(button_id_res), .part(part), .pressed(pressed), .last(last)
  );

  always #5 clk = ~clk;

  function automatic int floor_half(int s);
    return s >>> 1;
  endfunction

  function automatic int hat_x(int d);
    if (d == 5 || d == 6 || d == 7) return -1;
    if (d == 1 || d == 2 || d == 3) return 1;
    return 0;
  endfunction

  function automatic int hat_y(int d);
    if (d == 7 || d == 0 || d == 1) return -1;
    if (d == 3 || d == 4 || d == 5) return 1;
    return 0;
  endfunction

  function automatic int find_slot(logic [15:0] id);
    for (int i = 0; i < tbl_count; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int insert_slot(logic [15:0] id);
    int p;
    p = 0;
    if (find_slot(id) >= 0 || tbl_count >= MAX_ENTRIES) return -1;
    while (p < tbl_count && tbl_id[p] < id) p++;
    for (int i = tbl_count; i > p; i--) begin
      tbl_id[i] = tbl_id[i-1];
      tbl_axis[i] = tbl_axis[i-1];
      tbl_low[i] = tbl_low[i-1];
      tbl_high[i] = tbl_high[i-1];
      tbl_prev[i] = tbl_prev[i-1];
      tbl_flags[i] = tbl_flags[i-1];
    end
    tbl_count++;
    tbl_id[p] = id;
    tbl_axis[p] = 1'b0;
    tbl_low[p] = 0;
    tbl_high[p] = 0;
    tbl_prev[p] = 0;
    tbl_flags[p] = '0;
    return p;
  endfunction

  // works out the events one accepted word causes
  function automatic void predict_events(word_t w);
    event_t evs[$];
    event_t e;
    int p, v, hv, mid, mlo, mhi, px, py, nx, ny, hi_idx;
    bit want_lo, want_hi;
    v = w.val;
    hv = w.hi;
    case (w.op)
      OP_DEF_HAT: begin
        p = insert_slot(w.id);
        if (p >= 0) tbl_low[p] = v;
      end
      OP_DEF_AXIS: begin
        mid = floor_half(v + hv);
        mlo = floor_half(v + mid);
        mhi = floor_half(hv + mid);
        if (mlo >= mid) mlo = mid - 1;
        if (mhi <= mid) mhi = mid + 1;
        p = insert_slot(w.id);
        if (p >= 0) begin
          tbl_axis[p] = 1'b1;
          tbl_prev[p] = mid;
          tbl_low[p] = mlo;
          tbl_high[p] = mhi;
        end
      end
      OP_INPUT: begin
        p = find_slot(w.id);
        if (p >= 0) begin
          if (v != tbl_prev[p]) begin
            px = hat_x(tbl_prev[p] - tbl_low[p]);
            py = hat_y(tbl_prev[p] - tbl_low[p]);
            tbl_prev[p] = v;
            e.id = w.id;
            e.last = 1'b0;
            if (tbl_axis[p]) begin
              want_lo = v <= tbl_low[p];
              want_hi = !want_lo && v >= tbl_high[p];
              if (!want_hi && tbl_flags[p][1]) begin
                tbl_flags[p][1] = 1'b0; e.part = PART_H; e.pressed = 1'b0; evs.push_back(e);
              end
              if (!want_lo && tbl_flags[p][0]) begin
                tbl_flags[p][0] = 1'b0; e.part = PART_L; e.pressed = 1'b0; evs.push_back(e);
              end
              if (want_lo && !tbl_flags[p][0]) begin
                tbl_flags[p][0] = 1'b1; e.part = PART_L; e.pressed = 1'b1; evs.push_back(e);
              end
              if (want_hi && !tbl_flags[p][1]) begin
                tbl_flags[p][1] = 1'b1; e.part = PART_H; e.pressed = 1'b1; evs.push_back(e);
              end
            end else begin
              nx = hat_x(v - tbl_low[p]);
              ny = hat_y(v - tbl_low[p]);
              if (px != nx) begin
                if (px != 0) begin
                  e.part = (px < 0) ? PART_W : PART_E;
                  tbl_flags[p][(px < 0) ? 0 : 1] = 1'b0;
                  e.pressed = 1'b0; evs.push_back(e);
                end
                if (nx != 0) begin
                  e.part = (nx < 0) ? PART_W : PART_E;
                  tbl_flags[p][(nx < 0) ? 0 : 1] = 1'b1;
                  e.pressed = 1'b1; evs.push_back(e);
                end
              end
              if (py != ny) begin
                if (py != 0) begin
                  e.part = (py < 0) ? PART_N : PART_S;
                  tbl_flags[p][(py < 0) ? 2 : 3] = 1'b0;
                  e.pressed = 1'b0; evs.push_back(e);
                end
                if (ny != 0) begin
                  e.part = (ny < 0) ? PART_N : PART_S;
                  tbl_flags[p][(ny < 0) ? 2 : 3] = 1'b1;
                  e.pressed = 1'b1; evs.push_back(e);
                end
              end
            end
          end
        end else begin
          hi_idx = -1;
          for (int i = held.size() - 1; i >= 0; i--)
            if (held[i] == w.id) begin
              hi_idx = i;
              break;
            end
          e.id = w.id; e.part = PART_B; e.last = 1'b0;
          if (v != 0) begin
            if (hi_idx < 0 && held.size() < MAX_HOLDS) begin
              held.push_back(w.id);
              e.pressed = 1'b1; evs.push_back(e);
            end
          end else if (hi_idx >= 0) begin
            held.delete(hi_idx);
            e.pressed = 1'b0; evs.push_back(e);
          end
        end
      end
      default: begin
        for (int i = 0; i < tbl_count; i++)
          for (int b = 0; b < (tbl_axis[i] ? 2 : 4); b++)
            if (tbl_flags[i][b]) begin
              tbl_flags[i][b] = 1'b0;
              e.id = tbl_id[i];
              e.part = tbl_axis[i] ? 3'(PART_L + b) : 3'(PART_W + b);
              e.pressed = 1'b0; e.last = 1'b0;
              evs.push_back(e);
            end
        while (held.size() > 0) begin
          e.id = held.pop_back(); e.part = PART_B; e.pressed = 1'b0; e.last = 1'b0;
          evs.push_back(e);
        end
      end
    endcase
    while (evs.size() > 32) void'(evs.pop_back());
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endfunction

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_word(op_t op, logic [15:0] id, logic [15:0] val,
                                   logic [15:0] hi);
    word_t w;
    w.op = op; w.id = id; w.val = val; w.hi = hi;
    pending_words.push_back(w);
  endfunction

  // driver: one word offered per push, held until taken
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_events('{op_t'(action), button_id, value, range_high});
        words_sent++;
        send_gap = random_gap();
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_words.size() > 0) begin
          word_t w;
          w = pending_words.pop_front();
          push <= 1'b1;
          action <= w.op;
          button_id <= w.id;
          value <= w.val;
          range_high <= w.hi;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken event with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        idle_cycles <= 0;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event id=%h part=%0d pressed=%0b last=%0b", $time,
                   button_id_res, part, pressed, last);
          errors++;
        end else begin
          event_t x;
          x = expected_events.pop_front();
          if (x.id !== button_id_res || x.part !== part || x.pressed !== pressed ||
              x.last !== last) begin
            $display("%0t: mismatch expected id=%h part=%0d pressed=%0b last=%0b,",
                     $time, x.id, x.part, x.pressed, x.last,
                     " got id=%h part=%0d pressed=%0b last=%0b",
                     button_id_res, part, pressed, last);
            errors++;
          end
        end
      end else if (push && !full) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      // long hold-off once mid-run so the block backs up
      if (words_sent == 150 && hold_off == 0) hold_off = 300;
      if (hold_off > 1) begin
        hold_off--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap = random_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int k, op_sel;
    logic [15:0] id;
    // directed part
    add_word(OP_INPUT, 16'h0050, 16'sd1, 16'sd0);
    add_word(OP_DEF_HAT, 16'h0010, 16'sd100, 16'sd0);
    add_word(OP_DEF_HAT, 16'h0010, 16'sd0, 16'sd0);
    add_word(OP_DEF_AXIS, 16'h0020, 16'h8000, 16'h7FFF);
    add_word(OP_DEF_AXIS, 16'h0000, 16'sd0, 16'sd1);
    add_word(OP_DEF_AXIS, 16'hFFFF, 16'h7FFF, 16'h8000);
    add_word(OP_INPUT, 16'h0010, 16'sd101, 16'h7FFF);
    add_word(OP_INPUT, 16'h0010, 16'sd101, 16'sd0);
    add_word(OP_INPUT, 16'h0010, 16'sd105, 16'sd0);
    add_word(OP_INPUT, 16'h0010, 16'sd500, 16'sd0);
    add_word(OP_INPUT, 16'h0020, 16'h8000, 16'sd0);
    add_word(OP_INPUT, 16'h0020, 16'h7FFF, 16'sd0);
    add_word(OP_INPUT, 16'h0000, 16'sd1, 16'sd0);
    add_word(OP_INPUT, 16'h0050, 16'sd0, 16'sd0);
    add_word(OP_INPUT, 16'h0050, 16'h8000, 16'sd0);
    add_word(OP_INPUT, 16'h0051, 16'h0001, 16'sd0);
    add_word(OP_RELEASE, 16'hFFFF, 16'h7FFF, 16'h8000);
    for (int i = 0; i < 6; i++) add_word(OP_DEF_HAT, 16'(16'h0300 + i), 16'sd0, 16'sd0);
    add_word(OP_RELEASE, 16'h0000, 16'sd0, 16'sd0);
    // random part
    for (int i = 0; i < 310; i++) begin
      op_sel = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 11)];
      if (op_sel < 6) begin
        add_word(OP_DEF_HAT, id, 16'($urandom), 16'($urandom));
      end else if (op_sel < 12) begin
        add_word(OP_DEF_AXIS, id, 16'($urandom), 16'($urandom));
      end else if (op_sel < 95) begin
        k = $urandom_range(0, 3);
        add_word(OP_INPUT, id, (k == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)) +
                 ((k == 1) ? 16'h8000 : 16'h0000), 16'($urandom));
      end else begin
        add_word(OP_RELEASE, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      // hold-list fill so the full case is reached
      if (i == 120)
        for (int j = 0; j < 18; j++) add_word(OP_INPUT, 16'(16'h0600 + j), 16'sd1, 16'sd0);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !push);
    wait (expected_events.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_events.size() == 0 && empty) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_events.size() != 0 || !empty)
        $display("%0t: events left over expected=%0d", $time, expected_events.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
